### design/bdot_pkg.sv
// shared types and constants for the b-dot detumbling controller
// no dependencies; compiled before every other file of the block
package bdot_pkg;

  localparam int AXES            = 3;
  localparam int FIELD_WIDTH_DEF = 20;

  localparam int DT_W       = 20;
  localparam int GAIN_W     = 32;
  localparam int WEIGHT_W   = 17;
  localparam int LIMIT_W    = 15;
  localparam int DIP_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int RATE_W    = 32;
  localparam int MAG_W     = 48;
  localparam int CAP_SHIFT = 24;

  localparam int MUL_A_W  = 66;
  localparam int MUL_B_W  = 33;
  localparam int DIV_N_W  = 64;
  localparam int DIV_D_W  = 32;
  localparam int SQ_N_W   = 52;
  localparam int SQ_R_W   = SQ_N_W / 2;
  localparam int SQ_REM_W = SQ_R_W + 4;

  localparam logic [RATE_W-1:0]   RATE_MAX   = 32'h7FFF_FFFF;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h1_0000;
  localparam logic [DT_W-1:0]     US_PER_S   = 20'd1000000;
  localparam logic [DIP_W-2:0]    DIP_MAX    = 15'h7FFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN   = 3'd0,
    CFG_WEIGHT = 3'd1,
    CFG_LIMIT  = 3'd2,
    CFG_MIN_DT = 3'd3,
    CFG_MAX_DT = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIFF,
    ST_MUL_US,
    ST_DIV_RATE,
    ST_MUL_NEW,
    ST_MUL_OLD,
    ST_MUL_GAIN,
    ST_NORM,
    ST_SQ,
    ST_LIM_SQ,
    ST_SQRT,
    ST_SCL_MUL,
    ST_SCL_DIV,
    ST_OUT
  } state_e;

endpackage

### design/bdot_ifs.sv
// valid/ready channels of the b-dot controller: sample words in, dipole words out
// depends on bdot_pkg
interface bdot_smp_if #(
  parameter int FIELD_WIDTH = bdot_pkg::FIELD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [FIELD_WIDTH-1:0] field_x;
  logic signed [FIELD_WIDTH-1:0] field_y;
  logic signed [FIELD_WIDTH-1:0] field_z;
  logic [bdot_pkg::DT_W-1:0]     interval_us;

  modport source (output valid, cmd, field_x, field_y, field_z, interval_us, input ready);
  modport sink   (input valid, cmd, field_x, field_y, field_z, interval_us, output ready);
endinterface

interface bdot_dip_if;
  logic                             valid;
  logic                             ready;
  logic signed [bdot_pkg::DIP_W-1:0] dipole_x;
  logic signed [bdot_pkg::DIP_W-1:0] dipole_y;
  logic signed [bdot_pkg::DIP_W-1:0] dipole_z;
  logic                             limited;
  logic                             status;

  modport source (output valid, dipole_x, dipole_y, dipole_z, limited, status, input ready);
  modport sink   (input valid, dipole_x, dipole_y, dipole_z, limited, status, output ready);
endinterface

### design/bdot_detumble_controller.sv
// channel   dir  width                       contents
// smp_i     in   1 + 3*FIELD_WIDTH + 20      cmd, field x/y/z, interval_us
// dip_o     out  3*16 + 2                    dipole x/y/z, limited, status
// cfg       in   1 + 3 + 32                  write enable, register index, data
//
// clear, invalid and first samples skip the arithmetic and go from the check state to the output state.
// a full sample runs per axis a bit-serial multiply, a 64-step restoring divide and
// three more multiplies, then squares; over the limit, a 26-step square root and
// per-axis rescaling follow; multiplies and divides share one multiplier and divider.
// the multiplier stops once its operand runs out of set bits. one sample is in work
// at a time; a new one is taken while the last word waits in the output register.
// reset is asynchronous, sets configuration to its defaults and clears history and the output valid.
// depends on bdot_pkg and bdot_ifs
module bdot_detumble_controller #(
  parameter int FIELD_WIDTH = bdot_pkg::FIELD_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bdot_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bdot_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bdot_smp_if.sink                        smp_i,
  bdot_dip_if.source                      dip_o
);
  import bdot_pkg::*;

  localparam int AW         = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int DIV_CNT_W  = $clog2(DIV_N_W + 1);
  localparam int SQ_CNT_W   = $clog2(SQ_R_W + 1);
  localparam logic [AW-1:0] AX_LAST = AW'(AXES - 1);
  localparam logic signed [MUL_A_W-1:0] RATE_HI = MUL_A_W'(RATE_MAX);
  localparam logic signed [MUL_A_W-1:0] RATE_LO = -RATE_HI;
  localparam logic signed [MUL_A_W-1:0] HALF_LSB = MUL_A_W'(32768);

  state_e state_q, state_d;

  // configuration
  logic [GAIN_W-1:0]   gain_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [LIMIT_W-1:0]  limit_q;
  logic [DT_W-1:0]     min_dt_q;
  logic [DT_W-1:0]     max_dt_q;

  // captured word and history
  logic                          cmd_q;
  logic signed [FIELD_WIDTH-1:0] fld_q  [AXES];
  logic [DT_W-1:0]               dt_q;
  logic signed [FIELD_WIDTH-1:0] prev_q [AXES];
  logic signed [RATE_W-1:0]      filt_q [AXES];
  logic                          have_q;

  // per sample working state
  logic [MAG_W-1:0]       mag_q [AXES];
  logic                   neg_q [AXES];
  logic [MAG_W-1:0]       maxmag_q;
  logic                   shifted_q;
  logic                   limited_q;
  logic                   status_q;
  logic                   zero_q;
  logic                   sign_q;
  logic [AW-1:0]          ax_q;
  logic [SQ_N_W-1:0]      n2_q;
  logic signed [MUL_A_W-1:0] acc_q;

  // shift-add multiplier
  logic signed [MUL_A_W-1:0] mul_a_q, mul_p_q, mul_a_in;
  logic [MUL_B_W-1:0]        mul_b_q, mul_b_in;
  logic                      mul_start, mul_done;

  // restoring divider
  logic [DIV_N_W-1:0]   div_n_q, div_n_in;
  logic [DIV_D_W-1:0]   div_d_q, div_d_in;
  logic [DIV_D_W-1:0]   div_r_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic                 div_start, div_done;
  logic [DIV_D_W:0]     div_r2, div_sub;

  // square root, two bits a step
  logic [SQ_N_W-1:0]   sq_x_q;
  logic [SQ_REM_W-1:0] sq_rem_q, sq_rem2, sq_trial;
  logic [SQ_R_W-1:0]   sq_root_q;
  logic [SQ_CNT_W-1:0] sq_cnt_q;
  logic                sq_start, sq_done;
  logic [SQ_R_W:0]     root_ceil;

  // output register
  logic                    dip_valid_q;
  logic signed [DIP_W-1:0] dip_q [AXES];
  logic                    dlim_q, dstat_q;
  logic                    out_load;

  // datapath helpers
  logic                      smp_acc, invalid;
  logic [WEIGHT_W-1:0]       w_eff;
  logic [AW-1:0]             ax_nxt;
  logic signed [FIELD_WIDTH:0] diff;
  logic [FIELD_WIDTH:0]      dm;
  logic [RATE_W-1:0]         rm;
  logic signed [RATE_W-1:0]  raw;
  logic signed [MUL_A_W-1:0] sum, sum_sh;
  logic signed [RATE_W-1:0]  filt_new;
  logic [RATE_W-1:0]         fm;
  logic [MUL_A_W-1:0]        prod_rnd;
  logic [MAG_W-1:0]          prod_mag;
  logic                      over_cap;

  assign smp_acc  = smp_i.valid && smp_i.ready;
  assign invalid  = (dt_q == '0) || (dt_q < min_dt_q) || (dt_q > max_dt_q) || (limit_q == '0);
  assign w_eff    = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
  assign ax_nxt   = (ax_q == AX_LAST) ? '0 : ax_q + AW'(1);
  assign diff     = {fld_q[ax_q][FIELD_WIDTH-1], fld_q[ax_q]}
                  - {prev_q[ax_q][FIELD_WIDTH-1], prev_q[ax_q]};
  assign dm       = diff[FIELD_WIDTH] ? (FIELD_WIDTH+1)'(0) - diff : diff;
  assign rm       = (div_n_q > DIV_N_W'(RATE_MAX)) ? RATE_MAX : div_n_q[RATE_W-1:0];
  assign raw      = sign_q ? -$signed(rm) : $signed(rm);
  assign sum      = acc_q + mul_p_q + HALF_LSB;
  assign sum_sh   = sum >>> 16;
  assign filt_new = (sum_sh > RATE_HI) ? RATE_W'(RATE_HI)
                  : (sum_sh < RATE_LO) ? RATE_W'(RATE_LO) : sum_sh[RATE_W-1:0];
  assign fm       = filt_new[RATE_W-1] ? RATE_W'(0) - filt_new : filt_new;
  assign prod_rnd = (mul_p_q + HALF_LSB) >> 16;
  assign prod_mag = prod_rnd[MAG_W-1:0];
  assign over_cap = (maxmag_q[MAG_W-1:CAP_SHIFT] != '0);
  assign root_ceil = {1'b0, sq_root_q} + (SQ_R_W + 1)'(sq_rem_q != '0);

  assign mul_done = (mul_b_q == '0);
  assign div_done = (div_cnt_q == '0);
  assign sq_done  = (sq_cnt_q == '0);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= '0;
      weight_q <= '0;
      limit_q  <= '0;
      min_dt_q <= DT_W'(1);
      max_dt_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN:   gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_WEIGHT: weight_q <= cfg_data_i[WEIGHT_W-1:0];
        CFG_LIMIT:  limit_q  <= cfg_data_i[LIMIT_W-1:0];
        CFG_MIN_DT: min_dt_q <= cfg_data_i[DT_W-1:0];
        CFG_MAX_DT: max_dt_q <= cfg_data_i[DT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mul_a_in  = '0;
    mul_b_in  = '0;
    div_start = 1'b0;
    div_n_in  = '0;
    div_d_in  = '0;
    sq_start  = 1'b0;
    out_load  = 1'b0;
    smp_i.ready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        smp_i.ready = 1'b1;
        if (smp_i.valid) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (cmd_q == CMD_CLEAR || invalid || !have_q) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        mul_start = 1'b1;
        mul_a_in  = MUL_A_W'(dm);
        mul_b_in  = MUL_B_W'(US_PER_S);
        state_d   = ST_MUL_US;
      end
      ST_MUL_US: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_n_in  = mul_p_q[DIV_N_W-1:0];
          div_d_in  = DIV_D_W'(dt_q);
          state_d   = ST_DIV_RATE;
        end
      end
      ST_DIV_RATE: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a_in  = MUL_A_W'(raw);
          mul_b_in  = MUL_B_W'(w_eff);
          state_d   = ST_MUL_NEW;
        end
      end
      ST_MUL_NEW: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a_in  = MUL_A_W'(filt_q[ax_q]);
          mul_b_in  = MUL_B_W'(WEIGHT_ONE - w_eff);
          state_d   = ST_MUL_OLD;
        end
      end
      ST_MUL_OLD: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a_in  = MUL_A_W'(fm);
          mul_b_in  = MUL_B_W'(gain_q);
          state_d   = ST_MUL_GAIN;
        end
      end
      ST_MUL_GAIN: begin
        if (mul_done) begin
          state_d = (ax_q == AX_LAST) ? ST_NORM : ST_DIFF;
        end
      end
      ST_NORM: begin
        if (!over_cap) begin
          mul_start = 1'b1;
          mul_a_in  = MUL_A_W'(mag_q[ax_q]);
          mul_b_in  = MUL_B_W'(mag_q[ax_q]);
          state_d   = ST_SQ;
        end
      end
      ST_SQ: begin
        if (mul_done) begin
          mul_start = 1'b1;
          if (ax_q == AX_LAST) begin
            mul_a_in = MUL_A_W'(limit_q);
            mul_b_in = MUL_B_W'(limit_q);
            state_d  = ST_LIM_SQ;
          end else begin
            mul_a_in = MUL_A_W'(mag_q[ax_nxt]);
            mul_b_in = MUL_B_W'(mag_q[ax_nxt]);
          end
        end
      end
      ST_LIM_SQ: begin
        if (mul_done) begin
          if (shifted_q || (MUL_A_W'(n2_q) > mul_p_q)) begin
            sq_start = 1'b1;
            state_d  = ST_SQRT;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_SQRT: begin
        if (sq_done) begin
          mul_start = 1'b1;
          mul_a_in  = MUL_A_W'(mag_q[ax_q]);
          mul_b_in  = MUL_B_W'(limit_q);
          state_d   = ST_SCL_MUL;
        end
      end
      ST_SCL_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_n_in  = mul_p_q[DIV_N_W-1:0];
          div_d_in  = DIV_D_W'(root_ceil);
          state_d   = ST_SCL_DIV;
        end
      end
      ST_SCL_DIV: begin
        if (div_done) begin
          if (ax_q == AX_LAST) begin
            state_d = ST_OUT;
          end else begin
            mul_start = 1'b1;
            mul_a_in  = MUL_A_W'(mag_q[ax_nxt]);
            mul_b_in  = MUL_B_W'(limit_q);
            state_d   = ST_SCL_MUL;
          end
        end
      end
      ST_OUT: begin
        if (!dip_valid_q || dip_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // history, cleared by reset and by a clear word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        prev_q[a] <= '0;
        filt_q[a] <= '0;
      end
    end else if (state_q == ST_CHECK) begin
      if (cmd_q == CMD_CLEAR) begin
        have_q <= 1'b0;
        for (int a = 0; a < AXES; a++) begin
          prev_q[a] <= '0;
          filt_q[a] <= '0;
        end
      end else if (!invalid && !have_q) begin
        have_q <= 1'b1;
        for (int a = 0; a < AXES; a++) begin
          prev_q[a] <= fld_q[a];
        end
      end
    end else if (state_q == ST_MUL_OLD && mul_done) begin
      filt_q[ax_q] <= filt_new;
      prev_q[ax_q] <= fld_q[ax_q];
    end
  end

  // per sample datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (smp_acc) begin
          cmd_q    <= smp_i.cmd;
          fld_q[0] <= smp_i.field_x;
          fld_q[1] <= smp_i.field_y;
          fld_q[2] <= smp_i.field_z;
          dt_q     <= smp_i.interval_us;
        end
      end
      ST_CHECK: begin
        status_q  <= (cmd_q == CMD_SAMPLE) && invalid;
        zero_q    <= (cmd_q == CMD_CLEAR) || invalid || !have_q;
        limited_q <= 1'b0;
        shifted_q <= 1'b0;
        maxmag_q  <= '0;
        n2_q      <= '0;
        ax_q      <= '0;
      end
      ST_DIFF: sign_q <= diff[FIELD_WIDTH];
      ST_MUL_NEW: begin
        if (mul_done) begin
          acc_q <= mul_p_q;
        end
      end
      ST_MUL_OLD: begin
        if (mul_done) begin
          neg_q[ax_q] <= !filt_new[RATE_W-1] && (filt_new != '0);
        end
      end
      ST_MUL_GAIN: begin
        if (mul_done) begin
          mag_q[ax_q] <= prod_mag;
          if (prod_mag > maxmag_q) begin
            maxmag_q <= prod_mag;
          end
          ax_q <= ax_nxt;
        end
      end
      ST_NORM: begin
        if (over_cap) begin
          maxmag_q  <= maxmag_q >> 1;
          shifted_q <= 1'b1;
          for (int a = 0; a < AXES; a++) begin
            mag_q[a] <= mag_q[a] >> 1;
          end
        end
      end
      ST_SQ: begin
        if (mul_done) begin
          n2_q <= n2_q + mul_p_q[SQ_N_W-1:0];
          ax_q <= ax_nxt;
        end
      end
      ST_LIM_SQ: begin
        if (mul_done) begin
          limited_q <= shifted_q || (MUL_A_W'(n2_q) > mul_p_q);
        end
      end
      ST_SCL_DIV: begin
        if (div_done) begin
          mag_q[ax_q] <= (root_ceil == '0) ? '0 : div_n_q[MAG_W-1:0];
          ax_q        <= ax_nxt;
        end
      end
      default: ;
    endcase
  end

  // shift-add multiplier, one multiplier bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_b_q <= '0;
    end else if (mul_start) begin
      mul_b_q <= mul_b_in;
    end else if (!mul_done) begin
      mul_b_q <= mul_b_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_start) begin
      mul_a_q <= mul_a_in;
      mul_p_q <= '0;
    end else if (!mul_done) begin
      mul_a_q <= mul_a_q <<< 1;
      if (mul_b_q[0]) begin
        mul_p_q <= mul_p_q + mul_a_q;
      end
    end
  end

  // restoring divider, one quotient bit a cycle
  assign div_r2  = {div_r_q, div_n_q[DIV_N_W-1]};
  assign div_sub = div_r2 - {1'b0, div_d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (div_start) begin
      div_cnt_q <= DIV_CNT_W'(DIV_N_W);
    end else if (!div_done) begin
      div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_n_q <= div_n_in;
      div_d_q <= div_d_in;
      div_r_q <= '0;
    end else if (!div_done) begin
      if (!div_sub[DIV_D_W]) begin
        div_r_q <= div_sub[DIV_D_W-1:0];
        div_n_q <= {div_n_q[DIV_N_W-2:0], 1'b1};
      end else begin
        div_r_q <= div_r2[DIV_D_W-1:0];
        div_n_q <= {div_n_q[DIV_N_W-2:0], 1'b0};
      end
    end
  end

  // digit-by-digit square root
  assign sq_rem2  = {sq_rem_q[SQ_REM_W-3:0], sq_x_q[SQ_N_W-1 -: 2]};
  assign sq_trial = SQ_REM_W'({sq_root_q, 2'b01});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_cnt_q <= '0;
    end else if (sq_start) begin
      sq_cnt_q <= SQ_CNT_W'(SQ_R_W);
    end else if (!sq_done) begin
      sq_cnt_q <= sq_cnt_q - SQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_start) begin
      sq_x_q    <= n2_q;
      sq_rem_q  <= '0;
      sq_root_q <= '0;
    end else if (!sq_done) begin
      sq_x_q <= sq_x_q << 2;
      if (sq_rem2 >= sq_trial) begin
        sq_rem_q  <= sq_rem2 - sq_trial;
        sq_root_q <= {sq_root_q[SQ_R_W-2:0], 1'b1};
      end else begin
        sq_rem_q  <= sq_rem2;
        sq_root_q <= {sq_root_q[SQ_R_W-2:0], 1'b0};
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dip_valid_q <= 1'b0;
    end else if (out_load) begin
      dip_valid_q <= 1'b1;
    end else if (dip_o.ready) begin
      dip_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      dlim_q  <= limited_q;
      dstat_q <= status_q;
      for (int a = 0; a < AXES; a++) begin
        if (zero_q) begin
          dip_q[a] <= '0;
        end else if (mag_q[a] > MAG_W'(DIP_MAX)) begin
          dip_q[a] <= neg_q[a] ? -$signed({1'b0, DIP_MAX}) : $signed({1'b0, DIP_MAX});
        end else begin
          dip_q[a] <= neg_q[a] ? -$signed({1'b0, mag_q[a][DIP_W-2:0]})
                               : $signed({1'b0, mag_q[a][DIP_W-2:0]});
        end
      end
    end
  end

  assign dip_o.valid    = dip_valid_q;
  assign dip_o.dipole_x = dip_q[0];
  assign dip_o.dipole_y = dip_q[1];
  assign dip_o.dipole_z = dip_q[2];
  assign dip_o.limited  = dlim_q;
  assign dip_o.status   = dstat_q;

endmodule

### design/bdot_chk.sv
// port-level checker for the b-dot controller, bound to the top level
// depends on bdot_pkg and bdot_detumble_controller
module bdot_chk (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [bdot_pkg::DIP_W-1:0] dip_x_i,
  input logic [bdot_pkg::DIP_W-1:0] dip_y_i,
  input logic [bdot_pkg::DIP_W-1:0] dip_z_i,
  input logic                    limited_i,
  input logic                    status_i
);
  import bdot_pkg::*;

  logic [1:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // words taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i
      && $stable(dip_x_i) && $stable(dip_y_i) && $stable(dip_z_i)
      && $stable(limited_i) && $stable(status_i))
    else $error("dipole word changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q <= 2'd2) && (!out_valid_i || pend_q != 2'd0))
    else $error("dipole word without a matching sample word");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |-> !limited_i
      && dip_x_i == '0 && dip_y_i == '0 && dip_z_i == '0)
    else $error("invalid sample gave a nonzero dipole");

  a_pend_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 |-> !in_ready_i)
    else $error("sample taken with a word in work and one waiting");

endmodule

bind bdot_detumble_controller bdot_chk u_bdot_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (smp_i.valid),
  .in_ready_i  (smp_i.ready),
  .out_valid_i (dip_o.valid),
  .out_ready_i (dip_o.ready),
  .dip_x_i     (dip_o.dipole_x),
  .dip_y_i     (dip_o.dipole_y),
  .dip_z_i     (dip_o.dipole_z),
  .limited_i   (dip_o.limited),
  .status_i    (dip_o.status)
);
